[hw/rtl/bmpblit_pkg.sv]
// Shared constants, types and phase codes of the BMP blit unit.
`timescale 1ns / 1ps

package bmpblit_pkg;

    localparam int SCREEN_WIDTH  = 800;
    localparam int SCREEN_HEIGHT = 480;
    localparam int HEADER_BYTES  = 54;

    localparam int COL_W    = $clog2(SCREEN_WIDTH);
    localparam int ROW_W    = $clog2(SCREEN_HEIGHT);
    localparam int ADDR_W   = 19;
    localparam int COLOR_W  = 24;
    localparam int DIM_W    = 16;
    localparam int HIDX_W   = 6;
    localparam int ORGX_W   = 10;
    localparam int ORGY_W   = 9;
    localparam int CFG_W    = 10;
    localparam int SUM_W    = DIM_W + 1;

    localparam logic [ORGX_W-1:0] ORIGIN_X_RESET = ORGX_W'(200);
    localparam logic [ORGY_W-1:0] ORIGIN_Y_RESET = ORGY_W'(100);

    // header byte positions of the size fields (low 16 bits only)
    localparam logic [HIDX_W-1:0] WIDTH_LO_IDX  = HIDX_W'(18);
    localparam logic [HIDX_W-1:0] WIDTH_HI_IDX  = HIDX_W'(19);
    localparam logic [HIDX_W-1:0] HEIGHT_LO_IDX = HIDX_W'(22);
    localparam logic [HIDX_W-1:0] HEIGHT_HI_IDX = HIDX_W'(23);

    // configuration register indexes
    localparam logic CFG_ORIGIN_X = 1'b0;
    localparam logic CFG_ORIGIN_Y = 1'b1;

    // position of a byte inside one BGR pixel
    localparam logic [1:0] BYTE_BLUE  = 2'd0;
    localparam logic [1:0] BYTE_GREEN = 2'd1;
    localparam logic [1:0] BYTE_RED   = 2'd2;

    typedef enum logic [3:0] {
        PH_HEADER = 4'b0001,
        PH_PIXELS = 4'b0010,
        PH_PAD    = 4'b0100,
        PH_DONE   = 4'b1000
    } phase_t;

    // on-screen pixel waiting for its address
    typedef struct packed {
        logic [ROW_W-1:0]   row;
        logic [COL_W-1:0]   col;
        logic [COLOR_W-1:0] color;
    } pix_t;

endpackage

[hw/rtl/bmpblit_parser.sv]
// Byte-level BMP parser: header fields, row and pixel counters, screen clipping.
`timescale 1ns / 1ps

module bmpblit_parser
    import bmpblit_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [7:0]        in_byte,
    input  logic              in_start,
    input  logic [ORGX_W-1:0] origin_x,
    input  logic [ORGY_W-1:0] origin_y,
    output logic              pix_valid,
    input  logic              pix_ready,
    output pix_t              pix
);

    phase_t             phase_reg, phase_next;
    logic [HIDX_W-1:0]  hidx_reg, hidx_next;
    logic [DIM_W-1:0]   width_reg, width_next;
    logic [DIM_W-1:0]   height_reg, height_next;
    logic [DIM_W-1:0]   row_reg, row_next;
    logic [DIM_W-1:0]   col_reg, col_next;
    logic [1:0]         bip_reg, bip_next;
    logic [1:0]         pad_reg, pad_next;
    logic [7:0]         blue_reg, blue_next;
    logic [7:0]         green_reg, green_next;
    logic               pix_valid_reg;
    pix_t               pix_reg;

    // current state as seen by this byte (start mark clears it first)
    phase_t             cur_phase;
    logic [HIDX_W-1:0]  cur_hidx;
    logic [DIM_W-1:0]   cur_width, cur_height, cur_row, cur_col;
    logic [1:0]         cur_bip, cur_pad;

    logic [HIDX_W-1:0]  hidx_inc;
    logic [DIM_W-1:0]   col_inc, flip_row;
    logic [SUM_W-1:0]   row_inc, scol, srow;
    logic               emit, accept;

    assign accept    = in_valid && in_ready;
    assign in_ready  = !pix_valid_reg || pix_ready;
    assign pix_valid = pix_valid_reg;
    assign pix       = pix_reg;

    always_comb
    begin
        cur_phase  = in_start ? PH_HEADER : phase_reg;
        cur_hidx   = in_start ? '0 : hidx_reg;
        cur_width  = in_start ? '0 : width_reg;
        cur_height = in_start ? '0 : height_reg;
        cur_row    = in_start ? '0 : row_reg;
        cur_col    = in_start ? '0 : col_reg;
        cur_bip    = in_start ? '0 : bip_reg;
        cur_pad    = in_start ? '0 : pad_reg;

        hidx_inc = cur_hidx + HIDX_W'(1);
        col_inc  = cur_col + DIM_W'(1);
        row_inc  = SUM_W'(cur_row) + SUM_W'(1);
        flip_row = cur_height - DIM_W'(1) - cur_row;
        scol     = SUM_W'(origin_x) + SUM_W'(cur_col);
        srow     = SUM_W'(origin_y) + SUM_W'(flip_row);

        phase_next  = cur_phase;
        hidx_next   = cur_hidx;
        width_next  = cur_width;
        height_next = cur_height;
        row_next    = cur_row;
        col_next    = cur_col;
        bip_next    = cur_bip;
        pad_next    = cur_pad;
        blue_next   = blue_reg;
        green_next  = green_reg;
        emit        = 1'b0;

        unique case (cur_phase)
            PH_HEADER:
            begin
                if (cur_hidx == WIDTH_LO_IDX)
                    width_next[7:0] = in_byte;
                if (cur_hidx == WIDTH_HI_IDX)
                    width_next[15:8] = in_byte;
                if (cur_hidx == HEIGHT_LO_IDX)
                    height_next[7:0] = in_byte;
                if (cur_hidx == HEIGHT_HI_IDX)
                    height_next[15:8] = in_byte;
                hidx_next = hidx_inc;
                if (hidx_inc >= HIDX_W'(HEADER_BYTES))
                begin
                    row_next = '0;
                    col_next = '0;
                    bip_next = '0;
                    pad_next = '0;
                    phase_next = (width_next != '0 && height_next != '0) ? PH_PIXELS
                                                                         : PH_DONE;
                end
            end
            PH_PIXELS:
            begin
                if (cur_bip == BYTE_BLUE)
                begin
                    blue_next = in_byte;
                    bip_next  = BYTE_GREEN;
                end
                else if (cur_bip == BYTE_GREEN)
                begin
                    green_next = in_byte;
                    bip_next   = BYTE_RED;
                end
                else
                begin
                    bip_next = BYTE_BLUE;
                    emit = (scol < SUM_W'(SCREEN_WIDTH)) && (srow < SUM_W'(SCREEN_HEIGHT));
                    col_next = col_inc;
                    if (col_inc >= cur_width)
                    begin
                        col_next = '0;
                        pad_next = cur_width[1:0];
                        if (cur_width[1:0] != 2'd0)
                            phase_next = PH_PAD;
                        else if (row_inc >= SUM_W'(cur_height))
                            phase_next = PH_DONE;
                        else
                        begin
                            row_next   = row_inc[DIM_W-1:0];
                            phase_next = PH_PIXELS;
                        end
                    end
                end
            end
            PH_PAD:
            begin
                pad_next = cur_pad - 2'd1;
                if (pad_next == 2'd0)
                begin
                    if (row_inc >= SUM_W'(cur_height))
                        phase_next = PH_DONE;
                    else
                    begin
                        row_next   = row_inc[DIM_W-1:0];
                        phase_next = PH_PIXELS;
                    end
                end
            end
            PH_DONE:
            begin
                // drop trailing bytes until the next start mark
            end
            default:
            begin
                phase_next = PH_DONE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HEADER;
            hidx_reg      <= '0;
            width_reg     <= '0;
            height_reg    <= '0;
            row_reg       <= '0;
            col_reg       <= '0;
            bip_reg       <= '0;
            pad_reg       <= '0;
            pix_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                phase_reg  <= phase_next;
                hidx_reg   <= hidx_next;
                width_reg  <= width_next;
                height_reg <= height_next;
                row_reg    <= row_next;
                col_reg    <= col_next;
                bip_reg    <= bip_next;
                pad_reg    <= pad_next;
            end
            if (in_ready)
                pix_valid_reg <= accept && emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            blue_reg  <= blue_next;
            green_reg <= green_next;
        end
        if (accept && emit)
        begin
            pix_reg.row   <= srow[ROW_W-1:0];
            pix_reg.col   <= scol[COL_W-1:0];
            pix_reg.color <= {in_byte, green_reg, blue_reg};
        end
    end

endmodule

[hw/rtl/bmpblit_addr.sv]
// Address stage: row times screen width plus column, held in the output register.
`timescale 1ns / 1ps

module bmpblit_addr
    import bmpblit_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               pix_valid,
    output logic               pix_ready,
    input  pix_t               pix,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [ADDR_W-1:0]  out_address,
    output logic [COLOR_W-1:0] out_color
);

    logic               valid_reg;
    logic [ADDR_W-1:0]  address_reg, address_next;
    logic [COLOR_W-1:0] color_reg;

    assign pix_ready   = !valid_reg || out_ready;
    assign out_valid   = valid_reg;
    assign out_address = address_reg;
    assign out_color   = color_reg;

    assign address_next = ADDR_W'(pix.row) * ADDR_W'(SCREEN_WIDTH) + ADDR_W'(pix.col);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (pix_ready)
            valid_reg <= pix_valid;
    end

    always_ff @(posedge clk)
    begin
        if (pix_ready && pix_valid)
        begin
            address_reg <= address_next;
            color_reg   <= pix.color;
        end
    end

endmodule

[hw/rtl/bmp24_to_framebuffer_blit_unit.sv]
// Top level of the 24-bit BMP to framebuffer blit unit.
`timescale 1ns / 1ps
//
//  Channel   Direction  Ports                         Contents
//  --------  ---------  ----------------------------  ---------------------------------
//  s_*       in         s_tvalid/s_tready/s_tdata/    one BMP file byte per transfer,
//                       s_tuser                       tuser marks the first byte of a file
//  m_*       out        m_tvalid/m_tready/m_tdata     one framebuffer write per transfer
//  cfg_*     in         cfg_we/cfg_index/cfg_data     image origin on screen
//
//  One byte is taken every cycle while s_tready is high; the parser state advances at
//  each input transfer. A red byte of an on-screen pixel produces a write after passing
//  the parser's pixel register and then the address stage (the row * 800 multiply).
//  Each stage holds while the next one is full and stalled, so m_tready low backs up
//  to s_tready only after both stages fill.
//  Reset clears the parse state to the header phase and sets the origin to (200, 100).
//
module bmp24_to_framebuffer_blit_unit
    import bmpblit_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [7:0]       s_tdata,   // [7:0] file_byte
    input  logic             s_tuser,   // [0] file_start
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [47:0]      m_tdata,   // [18:0] pixel_address, [42:19] pixel_color, zeros
    input  logic             cfg_we,
    input  logic             cfg_index,
    input  logic [CFG_W-1:0] cfg_data
);

    logic [ORGX_W-1:0]  origin_x_reg;
    logic [ORGY_W-1:0]  origin_y_reg;
    logic               pix_valid, pix_ready;
    pix_t               pix;
    logic [ADDR_W-1:0]  pixel_address;
    logic [COLOR_W-1:0] pixel_color;

    // origin registers; the user must write them only while the block is idle (not enforced here)
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg <= ORIGIN_X_RESET;
            origin_y_reg <= ORIGIN_Y_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_ORIGIN_X: origin_x_reg <= cfg_data[ORGX_W-1:0];
                CFG_ORIGIN_Y: origin_y_reg <= cfg_data[ORGY_W-1:0];
                default:      origin_x_reg <= origin_x_reg;
            endcase
        end
    end

    bmpblit_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_byte   (s_tdata),
        .in_start  (s_tuser),
        .origin_x  (origin_x_reg),
        .origin_y  (origin_y_reg),
        .pix_valid (pix_valid),
        .pix_ready (pix_ready),
        .pix       (pix)
    );

    bmpblit_addr u_addr (
        .clk         (clk),
        .rst_n       (rst_n),
        .pix_valid   (pix_valid),
        .pix_ready   (pix_ready),
        .pix         (pix),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_address (pixel_address),
        .out_color   (pixel_color)
    );

    // pack the write, padded with zeros to whole bytes
    assign m_tdata = {5'd0, pixel_color, pixel_address};

endmodule

[bench/tb_bmp24_to_framebuffer_blit_unit.sv]
// Self-checking testbench of the 24-bit BMP to framebuffer blit unit.
`timescale 1ns / 1ps

module tb_bmp24_to_framebuffer_blit_unit;
    import bmpblit_pkg::*;

    // pixel register plus address stage
    localparam int PIPE_LAT     = 2;
    localparam int RANDOM_BYTES = 800;
    localparam int MAX_REPORTS  = 40;

    // One framebuffer write as the block should present it.
    typedef struct {
        logic [ADDR_W-1:0]  addr;
        logic [COLOR_W-1:0] color;
    } fb_write_t;

    // Tracks the parse of the byte stream, predicts framebuffer writes and checks them.
    class blit_scoreboard;
        logic [ORGX_W-1:0] org_x;
        logic [ORGY_W-1:0] org_y;
        phase_t            cur_phase;
        logic [HIDX_W-1:0] hdr_pos;
        logic [DIM_W-1:0]  width_px;
        logic [DIM_W-1:0]  height_px;
        logic [DIM_W-1:0]  row_in_file;
        logic [DIM_W-1:0]  col_in_row;
        logic [1:0]        bgr_pos;
        logic [1:0]        pad_left;
        logic [7:0]        blue_byte;
        logic [7:0]        green_byte;
        fb_write_t         expected_writes[$];
        int                fail_count;

        function new();
            org_x      = ORIGIN_X_RESET;
            org_y      = ORIGIN_Y_RESET;
            fail_count = 0;
            restart_parse();
        endfunction

        function void restart_parse();
            cur_phase   = PH_HEADER;
            hdr_pos     = '0;
            width_px    = '0;
            height_px   = '0;
            row_in_file = '0;
            col_in_row  = '0;
            bgr_pos     = BYTE_BLUE;
            pad_left    = '0;
            blue_byte   = '0;
            green_byte  = '0;
        endfunction

        function void set_origin(logic idx, logic [CFG_W-1:0] value);
            if (idx == CFG_ORIGIN_X)
                org_x = value[ORGX_W-1:0];
            else
                org_y = value[ORGY_W-1:0];
        endfunction

        function int pending();
            return expected_writes.size();
        endfunction

        // Finish a row: either the image is complete or the next file row starts.
        function void next_row();
            if (32'(row_in_file) + 1 >= 32'(height_px))
                cur_phase = PH_DONE;
            else
            begin
                row_in_file = row_in_file + 1'b1;
                cur_phase   = PH_PIXELS;
            end
        endfunction

        // Note one accepted file byte and queue the write it causes, if any.
        function void take_file_byte(logic [7:0] b, logic start);
            int unsigned scol;
            int unsigned srow;
            fb_write_t   wr;
            if (start)
                restart_parse();
            case (cur_phase)
                PH_HEADER:
                begin
                    if (hdr_pos == WIDTH_LO_IDX)
                        width_px[7:0] = b;
                    else if (hdr_pos == WIDTH_HI_IDX)
                        width_px[15:8] = b;
                    else if (hdr_pos == HEIGHT_LO_IDX)
                        height_px[7:0] = b;
                    else if (hdr_pos == HEIGHT_HI_IDX)
                        height_px[15:8] = b;
                    hdr_pos = hdr_pos + 1'b1;
                    if (32'(hdr_pos) >= HEADER_BYTES)
                    begin
                        row_in_file = '0;
                        col_in_row  = '0;
                        bgr_pos     = BYTE_BLUE;
                        pad_left    = '0;
                        cur_phase   = (width_px != 0 && height_px != 0) ? PH_PIXELS : PH_DONE;
                    end
                end
                PH_PIXELS:
                begin
                    if (bgr_pos == BYTE_BLUE)
                    begin
                        blue_byte = b;
                        bgr_pos   = BYTE_GREEN;
                    end
                    else if (bgr_pos == BYTE_GREEN)
                    begin
                        green_byte = b;
                        bgr_pos    = BYTE_RED;
                    end
                    else
                    begin
                        // flip vertically: the file's bottom row lands lowest on screen
                        scol    = 32'(org_x) + 32'(col_in_row);
                        srow    = 32'(org_y) + 32'(height_px) - 1 - 32'(row_in_file);
                        bgr_pos = BYTE_BLUE;
                        if (scol < SCREEN_WIDTH && srow < SCREEN_HEIGHT)
                        begin
                            wr.addr  = ADDR_W'(srow * SCREEN_WIDTH + scol);
                            wr.color = {b, green_byte, blue_byte};
                            expected_writes.push_back(wr);
                        end
                        col_in_row = col_in_row + 1'b1;
                        if (col_in_row >= width_px)
                        begin
                            col_in_row = '0;
                            pad_left   = width_px[1:0];
                            if (pad_left != 0)
                                cur_phase = PH_PAD;
                            else
                                next_row();
                        end
                    end
                end
                PH_PAD:
                begin
                    pad_left = pad_left - 1'b1;
                    if (pad_left == 0)
                        next_row();
                end
                default:
                    ;
            endcase
        endfunction

        task report(string msg);
            fail_count++;
            if (fail_count <= MAX_REPORTS)
                $display("%0t ns: mismatch: %s", $time, msg);
        endtask

        // Compare one accepted output word with the oldest predicted write.
        task check_write(logic [47:0] word);
            fb_write_t exp_wr;
            if (expected_writes.size() == 0)
            begin
                report($sformatf("write %h with nothing predicted", word));
                return;
            end
            exp_wr = expected_writes.pop_front();
            if (word[18:0] !== exp_wr.addr)
                report($sformatf("address %0d, predicted %0d", word[18:0], exp_wr.addr));
            if (word[42:19] !== exp_wr.color)
                report($sformatf("color %h, predicted %h at address %0d",
                                 word[42:19], exp_wr.color, exp_wr.addr));
            if (word[47:43] !== 5'd0)
                report($sformatf("fill bits %b are not zero", word[47:43]));
        endtask
    endclass

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             s_tvalid  = 1'b0;
    logic             s_tready;
    logic [7:0]       s_tdata   = 8'd0;   // [7:0] file_byte
    logic             s_tuser   = 1'b0;   // [0] file_start
    logic             m_tvalid;
    logic             m_tready  = 1'b0;
    logic [47:0]      m_tdata;            // [18:0] pixel_address, [42:19] pixel_color, zeros
    logic             cfg_we    = 1'b0;
    logic             cfg_index = 1'b0;
    logic [CFG_W-1:0] cfg_data  = '0;

    blit_scoreboard sb = new();
    int             bytes_sent = 0;
    bit             quiet_send = 1'b0;

    bmp24_to_framebuffer_blit_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #6 clk = ~clk;

    // Idle length for either side: mostly none or short, now and then long.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(15, 40);
    endfunction

    // Pixel data bytes: random, or all-zero / all-one to hit the color extremes.
    function automatic logic [7:0] data_byte(int fill);
        if (fill == 1)
            return 8'h00;
        if (fill == 2)
            return 8'hFF;
        return 8'($urandom);
    endfunction

    // Offer one file byte, hold it until the transfer, and note it.
    // Enters and leaves at a falling edge.
    task automatic push_byte(input logic [7:0] b, input logic start);
        int gap;
        gap = quiet_send ? 0 : idle_len();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= start;
        do
            @(posedge clk);
        while (!s_tready);
        sb.take_file_byte(b, start);
        bytes_sent++;
        @(negedge clk);
    endtask

    // Stop sending and hold until every predicted write has come out,
    // then let the pipeline settle.
    task automatic drain_writes();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (PIPE_LAT + 2) @(negedge clk);
    endtask

    // Move the image origin; only done with the block idle.
    task automatic set_origin(input logic [CFG_W-1:0] ox, input logic [CFG_W-1:0] oy);
        drain_writes();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_ORIGIN_X;
        cfg_data  <= ox;
        @(negedge clk);
        sb.set_origin(CFG_ORIGIN_X, ox);
        cfg_index <= CFG_ORIGIN_Y;
        cfg_data  <= oy;
        @(negedge clk);
        sb.set_origin(CFG_ORIGIN_Y, oy);
        cfg_we <= 1'b0;
    endtask

    // Stream one BMP file. The low 16 bits of each size field set the image;
    // the upper bits are stuffed with whatever the caller passes.
    // cut_at >= 0 stops the file early, trailing adds junk after it,
    // hold_at pauses the sender at that byte until all writes are out.
    task automatic send_file(input logic [31:0] w_field, input logic [31:0] h_field,
                             input bit with_start, input int cut_at, input int trailing,
                             input int fill, input int hold_at);
        longint     w;
        longint     h;
        longint     total;
        logic [7:0] b;
        w     = w_field[15:0];
        h     = h_field[15:0];
        total = HEADER_BYTES + h * (3 * w + (w % 4));
        if (cut_at >= 0 && cut_at < total)
            total = cut_at;
        for (longint pos = 0; pos < total; pos++)
        begin
            if (pos == hold_at)
                drain_writes();
            if (pos >= HEADER_BYTES)
                b = data_byte(fill);
            else
                case (int'(pos))
                    0:       b = 8'h42;
                    1:       b = 8'h4D;
                    18:      b = w_field[7:0];
                    19:      b = w_field[15:8];
                    20:      b = w_field[23:16];
                    21:      b = w_field[31:24];
                    22:      b = h_field[7:0];
                    23:      b = h_field[15:8];
                    24:      b = h_field[23:16];
                    25:      b = h_field[31:24];
                    default: b = 8'($urandom);
                endcase
            push_byte(b, with_start && pos == 0);
        end
        repeat (trailing) push_byte(8'($urandom), 1'b0);
    endtask

    function automatic logic [CFG_W-1:0] pick_origin_x();
        case ($urandom_range(0, 7))
            0:       return CFG_W'(0);
            1:       return CFG_W'(SCREEN_WIDTH - 1);
            2:       return CFG_W'(1023);
            default: return CFG_W'($urandom_range(0, 1023));
        endcase
    endfunction

    // Values with bit 9 set exercise the truncation into the 9-bit origin Y register.
    function automatic logic [CFG_W-1:0] pick_origin_y();
        case ($urandom_range(0, 7))
            0:       return CFG_W'(0);
            1:       return CFG_W'(SCREEN_HEIGHT - 1);
            2:       return CFG_W'(511);
            3:       return CFG_W'($urandom_range(512, 1023));
            default: return CFG_W'($urandom_range(0, 511));
        endcase
    endfunction

    // Sink: stall in random stretches, with long runs of steady ready now and then.
    initial
    begin
        int stall;
        forever
        begin
            @(negedge clk);
            stall = ($urandom_range(0, 5) == 0) ? 0 : idle_len();
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_tready <= 1'b1;
            repeat (($urandom_range(0, 9) == 0) ? $urandom_range(50, 200)
                                                : $urandom_range(0, 7)) @(negedge clk);
        end
    end

    // Check every output transfer against the oldest predicted write.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_write(m_tdata);
    end

    // Stimulus: a directed set of files, then random files until the byte budget is spent.
    initial
    begin
        int            kind;
        int            cut_at;
        int            directed_bytes;
        logic [31:0]   w_field;
        logic [31:0]   h_field;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // First file right after reset with no start mark, origin still at (200, 100);
        // the junk after the image must be ignored.
        send_file(32'd3, 32'd2, 1'b0, -1, 5, 0, -1);
        // Size fields with garbage in their upper halves, all-ones pixels, no padding.
        send_file(32'hABCD_0004, 32'h5A5A_0002, 1'b1, -1, 0, 2, -1);
        // Zero width, then zero height: header only, trailing bytes dropped.
        send_file(32'h1234_0000, 32'd3, 1'b1, -1, 6, 0, -1);
        send_file(32'd5, 32'hFFFF_0000, 1'b1, -1, 4, 0, -1);
        // Restart in the middle of the pixel data; all-zero pixels.
        send_file(32'd5, 32'd3, 1'b1, HEADER_BYTES + 20, 0, 1, -1);
        // Origin at the far corner: only the top-left pixel stays on screen.
        set_origin(CFG_W'(SCREEN_WIDTH - 1), CFG_W'(SCREEN_HEIGHT - 1));
        send_file(32'd3, 32'd3, 1'b1, -1, 0, 0, -1);
        // Origin at zero, and a pause mid-file until the sink has caught up.
        set_origin(CFG_W'(0), CFG_W'(0));
        send_file(32'd2, 32'd2, 1'b1, -1, 0, 0, HEADER_BYTES + 6);
        // Origin beyond the screen on both axes: nothing may come out.
        set_origin(CFG_W'(1023), CFG_W'(1023));
        send_file(32'd1, 32'd1, 1'b1, -1, 0, 0, -1);
        // Wide and tall image, cut short by the next file's start mark.
        set_origin(CFG_W'(0), CFG_W'(0));
        send_file(32'h0000_0101, 32'h0000_0200, 1'b1, HEADER_BYTES + 90, 0, 0, -1);
        directed_bytes = bytes_sent;

        // Random files: mostly small well-formed images, some degenerate,
        // some huge ones cut off early, occasional missing start marks and junk.
        while (bytes_sent < directed_bytes + RANDOM_BYTES)
        begin
            if ($urandom_range(0, 2) == 0)
                set_origin(pick_origin_x(), pick_origin_y());
            quiet_send = ($urandom_range(0, 5) == 0);
            kind       = $urandom_range(0, 19);
            cut_at     = -1;
            w_field    = {16'($urandom), 16'($urandom_range(1, 12))};
            h_field    = {16'($urandom), 16'($urandom_range(1, 6))};
            if (kind == 0)
                w_field[15:0] = '0;
            else if (kind == 1)
                h_field[15:0] = '0;
            else if (kind < 4)
            begin
                w_field = $urandom;
                h_field = $urandom;
                cut_at  = HEADER_BYTES + $urandom_range(0, 240);
            end
            else if ($urandom_range(0, 7) == 0)
                cut_at = $urandom_range(1, 200);
            send_file(w_field, h_field, $urandom_range(0, 15) != 0, cut_at,
                      ($urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 0,
                      ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : 0,
                      ($urandom_range(0, 19) == 0) ? $urandom_range(HEADER_BYTES,
                                                                    HEADER_BYTES + 60) : -1);
        end

        // Wait out every predicted write, then keep watching for stray writes.
        quiet_send = 1'b0;
        drain_writes();
        repeat (8) @(posedge clk);
        if (sb.fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Watchdog: several times the slowest legal run.
    initial
    begin
        #6_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
